/* design/ovn2d_pkg.sv */
`default_nettype none
package ovn2d_pkg;

	localparam int MAX_DIM     = 16;
	localparam int MAX_OCTAVES = 4;

	localparam int COORD_W  = $clog2(MAX_DIM);
	localparam int DIM_W    = COORD_W + 1;
	localparam int ADDR_W   = 2 * COORD_W;
	localparam int DEPTH    = MAX_DIM * MAX_DIM;
	localparam int OCT_W    = 3;
	localparam int SEED_W   = 8;
	localparam int RATIO_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;
	localparam int COEF_W   = 2 * DIM_W;
	localparam int NUM_W    = 16;
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 29;
	localparam int ACC_W    = 47;
	localparam int WSUM_W   = 31;
	localparam int DREM_W   = 32;
	localparam int DQ_W     = 16;
	localparam int DCNT_W   = 5;
	localparam int FRAC_W   = 12;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(4096);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RATIO = 2'd3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic [SEED_W-1:0]  seed_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] noise;
		logic        range_error;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_OCT, S_MODX, S_MODY, S_PREP, S_MODY2,
		S_READ, S_SSTART, S_SDIV, S_ACC, S_FDIV, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		DIV_MODX, DIV_MODY, DIV_MODY2, DIV_SAMPLE, DIV_FINAL
	} div_sel_t;

	typedef struct packed {
		logic       load;
		logic       seed_wr;
		logic       div_start;
		div_sel_t   div_sel;
		logic       prep;
		logic [1:0] rd_idx;
		logic       acc_en;
		logic [1:0] acc_idx;
		logic       oct_step;
	} cmd_t;

	typedef struct packed {
		logic query;
		logic range_err;
		logic oct_more;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

/* design/ovn2d_ram.sv */
`default_nettype none
module ovn2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* design/ovn2d_div.sv */
`default_nettype none
module ovn2d_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ovn2d_pkg::DCNT_W-1:0] iters,
	input  wire logic [ovn2d_pkg::DREM_W-1:0] r_init,
	input  wire logic [ovn2d_pkg::DQ_W-1:0]   q_init,
	input  wire logic [ovn2d_pkg::DREM_W-1:0] divisor,
	output logic                             done,
	output logic      [ovn2d_pkg::DQ_W-1:0]   quot,
	output logic      [ovn2d_pkg::DREM_W-1:0] rem
);
	import ovn2d_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [DREM_W-1:0] r_q, d_q, trial;
	logic [DQ_W-1:0]   q_q;
	logic              done_q, fits;

	// restoring step, one quotient bit a cycle
	assign trial = {r_q[DREM_W-2:0], q_q[DQ_W-1]};
	assign fits  = (trial >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= iters;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - DCNT_W'(1);
				done_q <= (cnt_q == DCNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= r_init;
			q_q <= q_init;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			r_q <= fits ? trial - d_q : trial;
			q_q <= {q_q[DQ_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

/* design/ovn2d_ctrl.sv */
`default_nettype none
module ovn2d_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ovn2d_pkg::status_t sts,
	output ovn2d_pkg::cmd_t        cmd,
	output logic                   busy,
	output logic                   done
);
	import ovn2d_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_READ) ? cnt_q + 3'd1 : 3'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_MODX;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!sts.query) begin
						cmd.seed_wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = sts.range_err ? S_DONE : S_OCT;
					end
				end
			end
			S_OCT: begin
				cmd.div_start = 1'b1;
				if (sts.oct_more) begin
					cmd.div_sel = DIV_MODX;
					state_d     = S_MODX;
				end else begin
					cmd.div_sel = DIV_FINAL;
					state_d     = S_FDIV;
				end
			end
			S_MODX: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_MODY;
					state_d       = S_MODY;
				end
			end
			S_MODY: begin
				if (sts.div_done) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep      = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MODY2;
				state_d       = S_MODY2;
			end
			S_MODY2: begin
				if (sts.div_done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_idx  = cnt_q[1:0];
				cmd.acc_en  = (cnt_q != 3'd0);
				cmd.acc_idx = 2'(cnt_q - 3'd1);
				if (cnt_q == 3'd4) begin
					state_d = S_SSTART;
				end
			end
			S_SSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SAMPLE;
				state_d       = S_SDIV;
			end
			S_SDIV: begin
				if (sts.div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.oct_step = 1'b1;
				state_d      = S_OCT;
			end
			S_FDIV: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
endmodule
`default_nettype wire

/* design/ovn2d_dpath.sv */
`default_nettype none
module ovn2d_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ovn2d_pkg::in_item_t             item,
	input  wire ovn2d_pkg::cmd_t                 cmd,
	input  wire logic                           cfg_we,
	input  wire logic [ovn2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ovn2d_pkg::CFG_W-1:0]     cfg_data,
	output ovn2d_pkg::status_t                   sts,
	output ovn2d_pkg::out_item_t                 result
);
	import ovn2d_pkg::*;

	logic [DIM_W-1:0]   gw_q, gh_q;
	logic [OCT_W-1:0]   oc_q;
	logic [RATIO_W-1:0] ratio_q;

	logic [DIM_W-1:0]   w_in, h_in, w_q, h_q, p_q;
	logic [OCT_W-1:0]   n_in, n_q, k_q;
	logic [COORD_W-1:0] x_q, y_q, dx_q, dy_q, y2_q, x1_q, y1_q, x2_q;
	logic [COEF_W-1:0]  coef_q [4];
	logic [NUM_W-1:0]   num_q;
	logic [SAMPLE_W-1:0] sample_q, noise_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [ACC_W-1:0]   acc_q;
	logic [WSUM_W-1:0]  wsum_q;
	logic               err_q;
	div_sel_t           sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= DIM_W'(10);
			gh_q    <= DIM_W'(10);
			oc_q    <= OCT_W'(2);
			ratio_q <= RATIO_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:   gw_q    <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT:  gh_q    <= cfg_data[DIM_W-1:0];
				REG_OCTAVE_COUNT: oc_q    <= cfg_data[OCT_W-1:0];
				REG_WEIGHT_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size and octave count
	assign w_in = (gw_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : gw_q;
	assign h_in = (gh_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : gh_q;
	always_comb begin
		n_in = oc_q;
		if (oc_q == '0) n_in = OCT_W'(1);
		if (oc_q > OCT_W'(MAX_OCTAVES)) n_in = OCT_W'(MAX_OCTAVES);
	end

	assign sts.query     = (item.func == FUNC_QUERY);
	assign sts.range_err = ({1'b0, item.x_pos} >= w_in) || ({1'b0, item.y_pos} >= h_in);
	assign sts.oct_more  = (k_q < n_q) && (p_q != '0);

	// seed store
	logic [ADDR_W-1:0]  raddr;
	logic [SEED_W-1:0]  rdata;
	always_comb begin
		case (cmd.rd_idx)
			2'd0:    raddr = {y1_q, x1_q};
			2'd1:    raddr = {y1_q, x2_q};
			2'd2:    raddr = {y2_q, x1_q};
			default: raddr = {y2_q, x2_q};
		endcase
	end

	ovn2d_ram #(.WIDTH(SEED_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.seed_wr),
		.waddr ({item.y_pos, item.x_pos}),
		.wdata (item.seed_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared divider operands
	logic [DCNT_W-1:0]  d_iters;
	logic [DREM_W-1:0]  d_rinit, d_div, d_rem;
	logic [DQ_W-1:0]    d_qinit, d_quot;
	logic               d_done;
	logic [COORD_W-1:0] y1_c;
	logic [DIM_W:0]     y1p_c;
	logic [2*DIM_W-1:0] psq;

	assign y1_c  = y_q - dy_q;
	assign y1p_c = {2'b0, y1_c} + {1'b0, p_q};
	assign psq   = p_q * p_q;

	always_comb begin
		d_iters = DCNT_W'(16);
		d_rinit = '0;
		d_qinit = '0;
		d_div   = DREM_W'(p_q);
		case (cmd.div_sel)
			DIV_MODX: begin
				d_iters = DCNT_W'(COORD_W);
				d_qinit = {x_q, (DQ_W-COORD_W)'(0)};
			end
			DIV_MODY: begin
				d_iters = DCNT_W'(COORD_W);
				d_qinit = {y_q, (DQ_W-COORD_W)'(0)};
			end
			DIV_MODY2: begin
				d_iters = DCNT_W'(DIM_W+1);
				d_qinit = {y1p_c, (DQ_W-DIM_W-1)'(0)};
				d_div   = DREM_W'(h_q);
			end
			DIV_SAMPLE: begin
				d_rinit = DREM_W'(num_q[NUM_W-1:8]);
				d_qinit = {num_q[7:0], 8'b0};
				d_div   = DREM_W'(psq);
			end
			DIV_FINAL: begin
				d_rinit = DREM_W'(acc_q[ACC_W-1:DQ_W]);
				d_qinit = acc_q[DQ_W-1:0];
				d_div   = DREM_W'(wsum_q);
			end
			default: ;
		endcase
	end

	ovn2d_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.iters   (d_iters),
		.r_init  (d_rinit),
		.q_init  (d_qinit),
		.divisor (d_div),
		.done    (d_done),
		.quot    (d_quot),
		.rem     (d_rem)
	);
	assign sts.div_done = d_done;

	// corner coordinates and blend weights
	logic [DIM_W:0]     x2_sum;
	logic [DIM_W-1:0]   pdx, pdy;
	assign x2_sum = {2'b0, x_q - dx_q} + {1'b0, p_q};
	assign pdx    = p_q - {1'b0, dx_q};
	assign pdy    = p_q - {1'b0, dy_q};

	logic [NUM_W+1:0]      num_sum;
	logic [WEIGHT_W+RATIO_W-1:0] wprod;
	logic [WEIGHT_W+SAMPLE_W-1:0] aprod;
	assign num_sum = {2'b0, num_q} + coef_q[cmd.acc_idx] * rdata;
	assign wprod   = weight_q * ratio_q;
	assign aprod   = weight_q * sample_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= item.x_pos;
			y_q      <= item.y_pos;
			w_q      <= w_in;
			h_q      <= h_in;
			n_q      <= n_in;
			p_q      <= w_in;
			k_q      <= '0;
			weight_q <= WEIGHT_ONE;
			acc_q    <= '0;
			wsum_q   <= '0;
			noise_q  <= '0;
			err_q    <= sts.range_err;
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (d_done) begin
			case (sel_q)
				DIV_MODX:   dx_q     <= d_rem[COORD_W-1:0];
				DIV_MODY:   dy_q     <= d_rem[COORD_W-1:0];
				DIV_MODY2:  y2_q     <= d_rem[COORD_W-1:0];
				DIV_SAMPLE: sample_q <= d_quot;
				DIV_FINAL:  noise_q  <= d_quot;
				default: ;
			endcase
		end
		if (cmd.prep) begin
			x1_q      <= x_q - dx_q;
			y1_q      <= y1_c;
			x2_q      <= (x2_sum >= {1'b0, w_q}) ? COORD_W'(x2_sum - {1'b0, w_q})
			                                     : COORD_W'(x2_sum);
			coef_q[0] <= pdx * pdy;
			coef_q[1] <= {1'b0, dx_q} * pdy;
			coef_q[2] <= pdx * {1'b0, dy_q};
			coef_q[3] <= {1'b0, dx_q} * {1'b0, dy_q};
			num_q     <= '0;
		end
		if (cmd.acc_en) begin
			num_q <= num_sum[NUM_W-1:0];
		end
		if (cmd.oct_step) begin
			acc_q    <= acc_q + ACC_W'(aprod);
			wsum_q   <= wsum_q + WSUM_W'(weight_q);
			weight_q <= wprod[FRAC_W +: WEIGHT_W];
			p_q      <= p_q >> 1;
			k_q      <= k_q + OCT_W'(1);
		end
	end

	assign result.noise       = noise_q;
	assign result.range_error = err_q;
endmodule
`default_nettype wire

/* design/octave_value_noise_2d.sv */
`default_nettype none
// fractal value noise over a wrapping seed grid of up to 16 x 16 Q0.8 seeds.
// a beat with func 0 writes one seed at the edge it is taken and gives no
// result, so writes can follow each other every cycle; a beat with func 1
// queries a cell and gives exactly one result, strobed by done for one cycle
// with no way to hold it off. a query outside the configured grid has done
// high in the first cycle after the accepting edge, with noise 0 and
// range_error 1. otherwise each octave runs the one shared bit-serial divider
// for x mod pitch, y mod pitch, the vertical wrap and the 16-bit sample
// divide, plus the four seed reads through the single read port and four
// single-state steps; the final normalizing divide of the weighted sum by
// the weight sum follows the last octave; done rises in the cycle after it.
// busy is high from the accepted query through its result cycle; start is
// taken only while busy is low, so the next beat is taken at the earliest at
// the edge after the one that ends the result cycle. configuration registers
// may be written at any clock but must change only while the block is idle
module octave_value_noise_2d (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire ovn2d_pkg::in_item_t             item,
	output logic                                done,
	output ovn2d_pkg::out_item_t                 result,
	input  wire logic                           cfg_we,
	input  wire logic [ovn2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ovn2d_pkg::CFG_W-1:0]     cfg_data
);
	import ovn2d_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer: walks octaves and steps the shared divider
	ovn2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: config registers, seed store, blend and weighting math
	ovn2d_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.result    (result)
	);
endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
	import ovn2d_pkg::*;

	// long enough for every item at its slowest plus the longest idle gaps
	localparam int CYCLE_LIMIT = 1000000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;
	logic      cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	octave_value_noise_2d u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the seed grid and the configuration
	logic [7:0]  seed_grid [MAX_DIM*MAX_DIM];
	logic [4:0]  cur_width;
	logic [4:0]  cur_height;
	logic [2:0]  cur_octaves;
	logic [15:0] cur_ratio;

	out_item_t   noise_expected [$];
	int          fail_count = 0;
	bit          idle_on;
	longint      cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a result never shows up
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("octave_value_noise_2d: mismatch");
			$finish;
		end
	end

	// weighted average over octaves of bilinear blends of four wrapped corners
	function automatic out_item_t predict_noise(logic [3:0] qx, logic [3:0] qy);
		out_item_t      r;
		longint unsigned w, h, n, p, wt, acc, wsum, res;
		longint unsigned dx, dy, x1, y1, x2, y2, num, smp;
		r.noise = '0;
		r.range_error = 1'b0;
		w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
		h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
		if (qx >= w || qy >= h) begin
			r.range_error = 1'b1;
			return r;
		end
		n = cur_octaves;
		if (n < 1) n = 1;
		if (n > MAX_OCTAVES) n = MAX_OCTAVES;
		p = w;
		wt = 4096;
		acc = 0;
		wsum = 0;
		for (longint unsigned k = 0; k < n && p > 0; k++) begin
			dx = qx % p;
			dy = qy % p;
			x1 = qx - dx;
			y1 = qy - dy;
			x2 = (x1 + p) % w;
			y2 = (y1 + p) % h;
			num = (p-dx)*(p-dy)*seed_grid[y1*MAX_DIM+x1]
			    + dx*(p-dy)*seed_grid[y1*MAX_DIM+x2]
			    + (p-dx)*dy*seed_grid[y2*MAX_DIM+x1]
			    + dx*dy*seed_grid[y2*MAX_DIM+x2];
			smp = (num * 256) / (p * p);
			acc += wt * smp;
			wsum += wt;
			wt = (wt * cur_ratio) >> 12;
			p >>= 1;
		end
		res = acc / wsum;
		if (res > 16'hFFFF) res = 16'hFFFF;
		r.noise = res[15:0];
		return r;
	endfunction

	// one beat in, with an optional random hold-off before it
	task automatic send_item(logic fn, logic [3:0] xp, logic [3:0] yp, logic [7:0] sv);
		in_item_t it;
		it.func = fn;
		it.x_pos = xp;
		it.y_pos = yp;
		it.seed_value = sv;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 17) - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		// taken at the first rising edge with busy low
		do @(posedge clk); while (busy);
		if (fn == FUNC_WRITE)
			seed_grid[{yp, xp}] = sv;
		else
			noise_expected = {noise_expected, predict_noise(xp, yp)};
	endtask

	// drop start and let any query in flight drain
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:   cur_width   = val[4:0];
			REG_GRID_HEIGHT:  cur_height  = val[4:0];
			REG_OCTAVE_COUNT: cur_octaves = val[2:0];
			REG_WEIGHT_RATIO: cur_ratio   = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [4:0] w, logic [4:0] h, logic [2:0] o, logic [15:0] r);
		wait_drained();
		write_reg(REG_GRID_WIDTH, CFG_W'(w));
		write_reg(REG_GRID_HEIGHT, CFG_W'(h));
		write_reg(REG_OCTAVE_COUNT, CFG_W'(o));
		write_reg(REG_WEIGHT_RATIO, r);
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && done) begin
			if (noise_expected.size() == 0) begin
				$error("result with nothing expected: noise %0h range_error %0b",
					result.noise, result.range_error);
				fail_count++;
			end else begin
				exp_r = noise_expected.pop_front();
				if (result.noise !== exp_r.noise) begin
					$error("noise expected %0h actual %0h", exp_r.noise, result.noise);
					fail_count++;
				end
				if (result.range_error !== exp_r.range_error) begin
					$error("range_error expected %0b actual %0b",
						exp_r.range_error, result.range_error);
					fail_count++;
				end
			end
		end
	end

	// every seed entry gets written first, so no query reads an unset entry
	task automatic test_seed_fill();
		for (int i = 0; i < MAX_DIM*MAX_DIM; i++)
			send_item(FUNC_WRITE, i[3:0], i[7:4],
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
	endtask

	task automatic test_directed();
		// reset configuration: in range, corners, and out of range
		send_item(FUNC_QUERY, 4'd0, 4'd0, 8'h00);
		send_item(FUNC_QUERY, 4'd9, 4'd9, 8'hFF);
		send_item(FUNC_QUERY, 4'd10, 4'd3, 8'h00);
		send_item(FUNC_QUERY, 4'd3, 4'd15, 8'h00);
		// full grid, most octaves, largest ratio
		set_config(5'd16, 5'd16, 3'd4, 16'hFFFF);
		send_item(FUNC_QUERY, 4'd15, 4'd15, 8'h00);
		send_item(FUNC_QUERY, 4'd7, 4'd0, 8'h00);
		// oversized grid acts as full size, count above max clamps
		set_config(5'd31, 5'd31, 3'd7, 16'd2048);
		send_item(FUNC_QUERY, 4'd15, 4'd1, 8'h00);
		send_item(FUNC_QUERY, 4'd5, 4'd13, 8'h00);
		// zero ratio, zero octave count
		set_config(5'd12, 5'd5, 3'd0, 16'd0);
		send_item(FUNC_QUERY, 4'd11, 4'd4, 8'h00);
		send_item(FUNC_QUERY, 4'd11, 4'd5, 8'h00);
		// one-wide, one-high grid: pitch dies after the first octave
		set_config(5'd1, 5'd1, 3'd4, 16'd4096);
		send_item(FUNC_QUERY, 4'd0, 4'd0, 8'h00);
		send_item(FUNC_QUERY, 4'd1, 4'd0, 8'h00);
		// zero size: always a range error
		set_config(5'd0, 5'd16, 3'd2, 16'd4096);
		send_item(FUNC_QUERY, 4'd0, 4'd0, 8'h00);
		set_config(5'd16, 5'd0, 3'd2, 16'd4096);
		send_item(FUNC_QUERY, 4'd0, 4'd0, 8'h00);
		// writes outside the configured grid still land
		set_config(5'd4, 5'd4, 3'd3, 16'd8192);
		send_item(FUNC_WRITE, 4'd15, 4'd15, 8'hA5);
		send_item(FUNC_QUERY, 4'd3, 4'd3, 8'h00);
	endtask

	task automatic test_random();
		logic [3:0] xp, yp;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(5'd16, 5'd16, 3'd4, 16'hFFFF);
				1: set_config(5'd1, 5'd1, 3'd1, 16'd0);
				default: set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					3'($urandom_range(0, 7)), 16'($urandom));
			endcase
			idle_on = (ph < 6);
			for (int i = 0; i < 65; i++) begin
				// mostly in-range queries, some strays and seed rewrites
				if ($urandom_range(0, 9) < 7 && cur_width != 0 && cur_height != 0
					&& $urandom_range(0, 7) != 0) begin
					xp = 4'($urandom_range(0, ((cur_width > 16) ? 16 : cur_width) - 1));
					yp = 4'($urandom_range(0, ((cur_height > 16) ? 16 : cur_height) - 1));
				end else begin
					xp = 4'($urandom);
					yp = 4'($urandom);
				end
				send_item(($urandom_range(0, 9) < 7) ? FUNC_QUERY : FUNC_WRITE,
					xp, yp, 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		cur_width = 5'd10;
		cur_height = 5'd10;
		cur_octaves = 3'd2;
		cur_ratio = 16'd4096;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_seed_fill();
		test_directed();
		test_random();

		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("octave_value_noise_2d: match");
		else
			$display("octave_value_noise_2d: mismatch");
		$finish;
	end
endmodule
